/* src/fret_pkg.sv */
// ---------------------------------------------------------------------------
// fret_pkg: shared types and constants for the FIFO rank error tracker
// Field widths, command and status codes, and the cell control group.
// ---------------------------------------------------------------------------
package fret_pkg;

    // Field widths of the item and result channels.
    localparam int KEY_W    = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int RANK_W   = 8;
    localparam int SUM_W    = 48;
    localparam int GCNT_W   = 32;
    localparam int OCC_W    = 9;

    // Default number of cells in the key list.
    localparam int DEF_LIST_DEPTH = 256;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic             put;
        logic [KEY_W-1:0] key;
    } t_cell_ctrl;

endpackage

/* src/fret_cell.sv */
// ---------------------------------------------------------------------------
// fret_cell: one slot of the ordered key list
// Holds one key, compares it against the broadcast key, loads a new key on
// append and takes its right neighbor's key when the list closes up.
// ---------------------------------------------------------------------------
module fret_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 9
) (
    input  logic                       i_clk,
    input  fret_pkg::t_cell_ctrl       i_ctrl,
    input  logic [CW-1:0]              i_count,
    input  logic                       i_shift,
    input  logic [fret_pkg::KEY_W-1:0] i_next_key,
    output logic [fret_pkg::KEY_W-1:0] o_key,
    output logic                       o_match
);
    import fret_pkg::*;

    localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

    logic [KEY_W-1:0] r_key;

    // The slot is occupied when its index lies below the key count.
    assign o_match = (MY_INDEX < i_count) && (r_key == i_ctrl.key);
    assign o_key   = r_key;

    // Append writes the first free slot; close-up takes the neighbor's key.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.put && (i_count == MY_INDEX)) begin
            r_key <= i_ctrl.key;
        end else if (i_shift) begin
            r_key <= i_next_key;
        end
    end

endmodule

/* src/fret_pick.sv */
// ---------------------------------------------------------------------------
// fret_pick: first-match selection over the cell row
// Isolates the lowest matching cell, encodes its position and builds the
// mask of cells that close up after its removal.
// ---------------------------------------------------------------------------
module fret_pick #(
    parameter int LIST_DEPTH = 256,
    parameter int PW         = 8
) (
    input  logic [LIST_DEPTH-1:0] i_match,
    output logic [LIST_DEPTH-1:0] o_shift,
    output logic                  o_found,
    output logic [PW-1:0]         o_pos
);
    import fret_pkg::*;

    logic [LIST_DEPTH-1:0] w_low;

    // Lowest set bit; every cell at or above it takes its neighbor's key.
    assign w_low   = i_match & (~i_match + LIST_DEPTH'(1));
    assign o_shift = ~(w_low - LIST_DEPTH'(1));
    assign o_found = |i_match;

    // Encode the one-hot position.
    always_comb begin
        o_pos = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (w_low[i]) begin
                o_pos = o_pos | PW'(i);
            end
        end
    end

endmodule

/* src/fifo_rank_error_tracker.sv */
// ---------------------------------------------------------------------------
// fifo_rank_error_tracker: rank error meter for relaxed queues
// Keeps keys in insertion order in a row of cells and measures how far each
// get strays from strict FIFO order.
// ---------------------------------------------------------------------------
// A put, a clear or an unused command executes in S_EXEC, after the edge that
// accepts it. Its result is registered as the block returns to S_IDLE, where
// it can accept the next item; the block takes one item at a time. A get goes
// on from S_EXEC, in which every cell compares its key against the item's key
// and the compare results are registered, to S_APPLY, which picks the
// earliest match, closes up the list and updates the statistics.
// The result register holds the last result; the block stalls in its final
// state only while that register is still occupied. The list holds
// LIST_DEPTH keys and comes out of reset empty with no clearing pass.
module fifo_rank_error_tracker #(
    parameter int LIST_DEPTH = fret_pkg::DEF_LIST_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [fret_pkg::CMD_W-1:0]    i_cmd,
    input  logic [fret_pkg::KEY_W-1:0]    i_key,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [fret_pkg::STATUS_W-1:0] o_status,
    output logic [fret_pkg::RANK_W-1:0]   o_displacement,
    output logic [fret_pkg::RANK_W-1:0]   o_max_rank_error,
    output logic [fret_pkg::SUM_W-1:0]    o_displacement_sum,
    output logic [fret_pkg::GCNT_W-1:0]   o_get_count,
    output logic [fret_pkg::OCC_W-1:0]    o_occupancy
);
    import fret_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int PW = $clog2(LIST_DEPTH);
    localparam int RW = (PW > RANK_W) ? PW : RANK_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(LIST_DEPTH);

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [CMD_W-1:0]      r_cmd;
    logic [KEY_W-1:0]      r_key;
    logic [LIST_DEPTH-1:0] r_match;
    logic [CW-1:0]         r_count, n_count;
    logic [RANK_W-1:0]     r_max, n_max;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [GCNT_W-1:0]     r_gets, n_gets;
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [RANK_W-1:0]     r_rank, n_rank;

    t_cell_ctrl            w_ctrl;
    logic [LIST_DEPTH-1:0] w_match;
    logic [LIST_DEPTH-1:0] w_shift;
    logic [KEY_W-1:0]      w_key [LIST_DEPTH];
    logic                  w_found;
    logic [PW-1:0]         w_pos;
    logic [RW-1:0]         w_pos_x;
    logic [RANK_W-1:0]     w_rank;
    logic [SUM_W:0]        w_sum_add;
    logic                  w_slot_free;
    logic                  w_exec_fire;
    logic                  w_apply_fire;
    logic                  w_in_fire;

    assign w_in_fire    = i_in_valid && o_in_ready;
    assign w_slot_free  = !r_out_valid || i_out_ready;
    assign w_exec_fire  = (r_state == S_EXEC) && (r_cmd != CMD_GET) && w_slot_free;
    assign w_apply_fire = (r_state == S_APPLY) && w_slot_free;

    // Broadcast to the cells: append only when the list has room.
    assign w_ctrl.put = w_exec_fire && (r_cmd == CMD_PUT) && (r_count != FULL_COUNT);
    assign w_ctrl.key = r_key;

    // Row of key cells; each one takes its right neighbor's key on close-up.
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic [KEY_W-1:0] w_next;
        if (g == LIST_DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_key[g+1];
        end
        fret_cell #(
            .INDEX (g),
            .CW    (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_count    (r_count),
            .i_shift    (w_shift[g] && w_apply_fire),
            .i_next_key (w_next),
            .o_key      (w_key[g]),
            .o_match    (w_match[g])
        );
    end

    // Earliest match over the registered compare results.
    fret_pick #(
        .LIST_DEPTH (LIST_DEPTH),
        .PW         (PW)
    ) u_pick (
        .i_match (r_match),
        .o_shift (w_shift),
        .o_found (w_found),
        .o_pos   (w_pos)
    );

    // Rank saturates at the result width; the sum takes the full position.
    assign w_pos_x   = RW'(w_pos);
    assign w_rank    = (w_pos_x > RW'(8'hFF)) ? 8'hFF : w_pos_x[RANK_W-1:0];
    assign w_sum_add = {1'b0, r_sum} + (SUM_W + 1)'(w_pos);

    // Sequencer and statistics.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_max       = r_max;
        n_sum       = r_sum;
        n_gets      = r_gets;
        n_status    = r_status;
        n_rank      = r_rank;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_cmd == CMD_GET) begin
                    n_state = S_APPLY;
                end else if (w_exec_fire) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_rank      = '0;
                    if (r_cmd == CMD_PUT) begin
                        if (r_count == FULL_COUNT) begin
                            n_status = ST_FULL;
                        end else begin
                            n_count = r_count + CW'(1);
                        end
                    end else if (r_cmd == CMD_CLEAR) begin
                        n_count = '0;
                        n_max   = '0;
                        n_sum   = '0;
                        n_gets  = '0;
                    end
                end
            end
            S_APPLY: begin
                if (w_apply_fire) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    if (w_found) begin
                        n_status = ST_OK;
                        n_rank   = w_rank;
                        n_count  = r_count - CW'(1);
                        if (w_rank > r_max) begin
                            n_max = w_rank;
                        end
                        n_sum = w_sum_add[SUM_W] ? '1 : w_sum_add[SUM_W-1:0];
                        if (r_gets != '1) begin
                            n_gets = r_gets + GCNT_W'(1);
                        end
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_rank   = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and statistics registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_max       <= '0;
            r_sum       <= '0;
            r_gets      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_max       <= n_max;
            r_sum       <= n_sum;
            r_gets      <= n_gets;
            r_out_valid <= n_out_valid;
        end
    end

    // Item capture, compare results and result payload.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_cmd <= i_cmd;
            r_key <= i_key;
        end
        if (r_state == S_EXEC) begin
            r_match <= w_match;
        end
        r_status <= n_status;
        r_rank   <= n_rank;
    end

    // Statistics change only when a result is loaded, so they drive the port.
    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_displacement     = r_rank;
    assign o_max_rank_error   = r_max;
    assign o_displacement_sum = r_sum;
    assign o_get_count        = r_gets;
    assign o_occupancy        = OCC_W'(r_count);

    // The key count never exceeds the list depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("key count above list depth");

    // Only a successful get reports a nonzero rank error.
    a_rank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_displacement == '0))
        else $error("rank error on a failed item");

    // The running maximum covers the rank error just reported.
    a_max_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_max_rank_error >= o_displacement))
        else $error("maximum below reported rank error");

    // A removal shortens the list by exactly one key.
    a_get_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_apply_fire && w_found) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("key count not reduced by a removal");

endmodule
